// ===== design/pfh_pkg.sv =====
// Shared types and constants for the capture-file flow hasher.
package pfh_pkg;

	localparam int unsigned REC_HDR_BYTES = 16;
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;
	localparam logic [7:0] BYTE_MASK = 8'hff;

	localparam int unsigned CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] CFG_FILE_HDR = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_LINK_HDR = 1'd1;

	localparam logic [7:0] FILE_HDR_RESET = 8'd24;
	localparam logic [6:0] LINK_HDR_RESET = 7'd14;

	// Per-record parser state.
	typedef struct packed {
		logic [31:0] pos;
		logic [31:0] cap_len;
		logic [3:0]  ihl;
		logic [7:0]  proto;
		logic [7:0]  addr_fold;
		logic [7:0]  port_fold;
	} rec_state_t;

	// One finished record.
	typedef struct packed {
		logic [31:0] offset;
		logic [31:0] length;
		logic [7:0]  flow_id;
		logic        is_tcp_or_udp;
	} rec_result_t;

endpackage

// ===== design/pfh_step.sv =====
// Next-state and result logic of the parser for one capture-file byte.
module pfh_step #(
	parameter int OFFSET_BITS = 32
) (
	input  logic [7:0]             data_byte,
	input  logic                   file_start,
	input  logic [7:0]             file_hdr_bytes,
	input  logic [6:0]             link_hdr_bytes,
	input  logic [OFFSET_BITS-1:0] fpos_in,
	input  logic [OFFSET_BITS-1:0] rstart_in,
	input  logic                   hdr_done_in,
	input  pfh_pkg::rec_state_t    rec_in,
	output logic [OFFSET_BITS-1:0] fpos_out,
	output logic [OFFSET_BITS-1:0] rstart_out,
	output logic                   hdr_done_out,
	output pfh_pkg::rec_state_t    rec_out,
	output logic                   emit,
	output pfh_pkg::rec_result_t   result
);

	logic [OFFSET_BITS-1:0] fpos;
	logic [31:0]            p;
	logic [31:0]            rel;
	logic [31:0]            total;
	logic [7:0]             ip_base;
	logic [5:0]             port_base;
	logic                   tu;

	assign ip_base = 8'(pfh_pkg::REC_HDR_BYTES) + {1'b0, link_hdr_bytes};

	always_comb begin
		fpos         = fpos_in;
		rstart_out   = rstart_in;
		hdr_done_out = hdr_done_in;
		rec_out      = rec_in;
		emit         = 1'b0;
		p            = '0;
		rel          = '0;
		total        = '0;
		port_base    = '0;
		tu           = 1'b0;

		if (file_start) begin
			fpos         = '0;
			rstart_out   = '0;
			hdr_done_out = 1'b0;
			rec_out      = '0;
		end

		if (!hdr_done_out && fpos >= OFFSET_BITS'(file_hdr_bytes)) begin
			hdr_done_out = 1'b1;
			rec_out      = '0;
		end

		if (hdr_done_out) begin
			p = rec_out.pos;
			if (p == 32'd0) begin
				rec_out    = '0;
				rstart_out = fpos;
			end
			// Captured length sits little-endian in bytes 8 to 11 of the record header.
			if (p >= 32'd8 && p <= 32'd11) begin
				rec_out.cap_len = rec_out.cap_len | (32'(data_byte) << {p[1:0], 3'b000});
			end
			if (p >= 32'(ip_base)) begin
				rel = p - 32'(ip_base);
				if (rel == 32'd0) begin
					rec_out.ihl = data_byte[3:0];
				end
				if (rel == 32'd9) begin
					rec_out.proto = data_byte;
				end
				if (rel >= 32'd12 && rel <= 32'd19) begin
					rec_out.addr_fold = rec_out.addr_fold ^ data_byte;
				end
				port_base = {rec_out.ihl, 2'b00};
				if (rel >= 32'(port_base) && (rel - 32'(port_base)) <= 32'd3) begin
					rec_out.port_fold = rec_out.port_fold ^ data_byte;
				end
			end
			total = rec_out.cap_len + 32'(pfh_pkg::REC_HDR_BYTES);
			if (p >= 32'(pfh_pkg::REC_HDR_BYTES - 1) && (p + 32'd1) == total) begin
				emit        = 1'b1;
				rec_out.pos = '0;
			end else begin
				rec_out.pos = p + 32'd1;
			end
		end

		tu = (rec_out.proto == pfh_pkg::PROTO_TCP) || (rec_out.proto == pfh_pkg::PROTO_UDP);
		result.offset        = 32'(rstart_out);
		result.length        = total;
		result.flow_id       = tu ? ((rec_out.addr_fold ^ rec_out.port_fold) & pfh_pkg::BYTE_MASK)
		                          : 8'd0;
		result.is_tcp_or_udp = tu;
		fpos_out             = fpos + OFFSET_BITS'(1);
	end

endmodule

// ===== design/pcap_record_flow_hasher_top.sv =====
// Top level of the capture-file record parser and flow hasher.
// Capture-file bytes enter one word per cycle. Each accepted word is held in an input
// register and processed when the result register is free or being emptied, when the parser state
// and the result register are updated together; a record's result is loaded as its last byte is processed.
// The sustained rate is one byte per cycle, bounded by the state update loop
// in pfh_step, and input stalls only while a held result is not taken. Configuration is
// read directly by the parser and should change only while no bytes are in flight.
module pcap_record_flow_hasher_top #(
	parameter int OFFSET_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [pfh_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_wr_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] data_byte
	input  logic                          s_tuser,   // [0] file_start
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [71:0]                   m_tdata,   // [31:0] record_offset, [63:32] record_length, [71:64] flow_id
	output logic                          m_tuser    // [0] is_tcp_or_udp
);

	logic [7:0]             file_hdr_q;
	logic [6:0]             link_hdr_q;

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   fstart_s1;

	logic [OFFSET_BITS-1:0] fpos_q;
	logic [OFFSET_BITS-1:0] rstart_q;
	logic                   hdr_done_q;
	pfh_pkg::rec_state_t    rec_q;

	logic [OFFSET_BITS-1:0] fpos_d;
	logic [OFFSET_BITS-1:0] rstart_d;
	logic                   hdr_done_d;
	pfh_pkg::rec_state_t    rec_d;
	logic                   emit;
	pfh_pkg::rec_result_t   result;

	logic                   out_valid_q;
	pfh_pkg::rec_result_t   out_q;
	logic                   advance;

	// The input register moves on whenever the result register is free or being emptied.
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = advance || !valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_hdr_q <= pfh_pkg::FILE_HDR_RESET;
			link_hdr_q <= pfh_pkg::LINK_HDR_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pfh_pkg::CFG_FILE_HDR: file_hdr_q <= cfg_wr_data;
				pfh_pkg::CFG_LINK_HDR: link_hdr_q <= cfg_wr_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1   <= s_tdata;
			fstart_s1 <= s_tuser;
		end
	end

	pfh_step #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_step (
		.data_byte      (byte_s1),
		.file_start     (fstart_s1),
		.file_hdr_bytes (file_hdr_q),
		.link_hdr_bytes (link_hdr_q),
		.fpos_in        (fpos_q),
		.rstart_in      (rstart_q),
		.hdr_done_in    (hdr_done_q),
		.rec_in         (rec_q),
		.fpos_out       (fpos_d),
		.rstart_out     (rstart_d),
		.hdr_done_out   (hdr_done_d),
		.rec_out        (rec_d),
		.emit           (emit),
		.result         (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fpos_q      <= '0;
			rstart_q    <= '0;
			hdr_done_q  <= 1'b0;
			rec_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && emit;
			if (valid_s1) begin
				fpos_q     <= fpos_d;
				rstart_q   <= rstart_d;
				hdr_done_q <= hdr_done_d;
				rec_q      <= rec_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.flow_id, out_q.length, out_q.offset};
	assign m_tuser  = out_q.is_tcp_or_udp;

endmodule
